>>> rtl/assert_macros.svh
// assertion helpers used by the checker file sfh_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, sampled on the block clock, off while reset is high
`define SFH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// same-cycle implication
`define SFH_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SFH_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/sfh_pkg.sv
// ----------------------------------------------------------------------------
// sfh_pkg
// Shared constants and types of the serial command frame handler.
// ----------------------------------------------------------------------------
package sfh_pkg;

   localparam int unsigned MAX_FRAME_LEN_DEF = 32;
   localparam int unsigned NUM_PINS          = 32;
   localparam int unsigned LEVEL_PINS        = 32;
   localparam int unsigned QUEUE_DEPTH       = 4;
   localparam int unsigned FRAME_OVERHEAD    = 5;

   localparam logic [7:0] START_BYTE = 8'h69;
   localparam logic [7:0] END_BYTE   = 8'h96;
   localparam logic [7:0] OP_DAC     = 8'h10;
   localparam logic [7:0] OP_DRIVE   = 8'h11;
   localparam logic [7:0] OP_READ    = 8'h12;
   localparam logic [7:0] LEN_DAC    = 8'd3;
   localparam logic [7:0] LEN_DRIVE  = 8'd2;
   localparam logic [7:0] LEN_READ   = 8'd1;
   localparam logic [7:0] ACK_DAC    = 8'h80;
   localparam logic [7:0] ACK_PIN    = 8'h81;
   localparam logic [7:0] ACK_ERR    = 8'hfe;
   localparam logic [7:0] READ_TAG   = 8'h01;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [1:0] DAC_MODE   = 2'b11;

   // command kinds carried through the queue
   localparam logic [1:0] KIND_DAC   = 2'd0;
   localparam logic [1:0] KIND_DRIVE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;
   localparam logic [1:0] KIND_ERR   = 2'd3;

   localparam logic [1:0] PIN_ACT_NONE  = 2'd0;
   localparam logic [1:0] PIN_ACT_DRIVE = 2'd1;
   localparam logic [1:0] PIN_ACT_INPUT = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] dac_word;
      logic [1:0]  pin_action;
      logic [7:0]  pin_number;
      logic        pin_drive;
      logic        read_bit;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  reply_byte;
      logic        reply_last;
      logic        dac_write;
      logic [15:0] dac_word;
      logic [1:0]  pin_action;
      logic [7:0]  pin_number;
      logic        pin_drive;
   } rsp_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } push_type;

endpackage

>>> rtl/sfh_front.sv
// ----------------------------------------------------------------------------
// sfh_front
// Frame parser: tracks the frame position, checks length, sum and end byte,
// and turns each valid frame into one command record.
// ----------------------------------------------------------------------------
module sfh_front #(
   parameter int unsigned MAX_FRAME_LEN = sfh_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic [31:0]        in_levels,
   input  logic               queue_full,
   output logic               in_ready,
   output sfh_pkg::push_type  push_out
);

   localparam int unsigned PW = $clog2(MAX_FRAME_LEN);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    opcode_ff, opcode_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    prev_ff, prev_in;
   logic [7:0]    first_data_ff [3];

   logic          accept;
   logic [8:0]    pos9;
   logic [8:0]    len9;
   logic          data_phase;
   logic          end_phase;
   logic          too_long;
   logic          fd_we;
   logic [1:0]    fd_idx;
   logic          good_end;
   logic [7:0]    pin;
   logic          pin_ok;
   logic          read_bit;
   sfh_pkg::cmd_type cmd;
   logic          cmd_keep;

   assign accept   = in_valid && !queue_full;
   assign in_ready = !queue_full;

   assign pos9       = 9'(pos_ff);
   assign len9       = {1'b0, len_ff};
   assign data_phase = pos9 < (len9 + 9'd3);
   assign end_phase  = pos9 == (len9 + 9'd4);
   assign too_long   = ({1'b0, in_byte} + 9'(sfh_pkg::FRAME_OVERHEAD)) > 9'(MAX_FRAME_LEN);
   assign fd_idx     = 2'(pos9 - 9'd3);

   always_comb begin
      pos_in    = pos_ff;
      opcode_in = opcode_ff;
      len_in    = len_ff;
      sum_in    = sum_ff;
      prev_in   = prev_ff;
      fd_we     = 1'b0;
      good_end  = 1'b0;
      if (accept) begin
         prev_in = in_byte;
         if (pos9 == 9'd0) begin
            if (in_byte == sfh_pkg::START_BYTE) begin
               sum_in = 8'd0;
               pos_in = PW'(1);
            end
         end else if (pos9 == 9'd1) begin
            opcode_in = in_byte;
            pos_in    = PW'(2);
         end else if (pos9 == 9'd2) begin
            len_in = in_byte;
            pos_in = too_long ? '0 : PW'(3);
         end else begin
            if (data_phase) begin
               sum_in = sum_ff + in_byte;
               fd_we  = pos9 <= 9'd5;
            end
            if (end_phase) begin
               pos_in   = '0;
               good_end = (in_byte == sfh_pkg::END_BYTE) && (prev_ff == sum_ff);
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   // dispatch of a finished frame
   assign pin      = first_data_ff[0];
   assign pin_ok   = {1'b0, pin} < 9'(sfh_pkg::NUM_PINS);
   assign read_bit = (pin_ok && ({1'b0, pin} < 9'(sfh_pkg::LEVEL_PINS))) ?
                     in_levels[pin[4:0]] : 1'b0;

   always_comb begin
      cmd      = '0;
      cmd_keep = 1'b1;
      case (opcode_ff)
         sfh_pkg::OP_DAC: begin
            cmd.kind     = sfh_pkg::KIND_DAC;
            cmd.dac_word = {first_data_ff[0][1:0], sfh_pkg::DAC_MODE,
                            first_data_ff[1][3:0], first_data_ff[2]};
            cmd_keep     = len_ff == sfh_pkg::LEN_DAC;
         end
         sfh_pkg::OP_DRIVE: begin
            cmd.kind       = sfh_pkg::KIND_DRIVE;
            cmd.pin_action = pin_ok ? sfh_pkg::PIN_ACT_DRIVE : sfh_pkg::PIN_ACT_NONE;
            cmd.pin_number = pin;
            cmd.pin_drive  = |first_data_ff[1];
            cmd_keep       = len_ff == sfh_pkg::LEN_DRIVE;
         end
         sfh_pkg::OP_READ: begin
            cmd.kind       = sfh_pkg::KIND_READ;
            cmd.pin_action = pin_ok ? sfh_pkg::PIN_ACT_INPUT : sfh_pkg::PIN_ACT_NONE;
            cmd.pin_number = pin;
            cmd.read_bit   = read_bit;
            cmd_keep       = len_ff == sfh_pkg::LEN_READ;
         end
         default: begin
            cmd.kind = sfh_pkg::KIND_ERR;
         end
      endcase
   end

   assign push_out.push = good_end && cmd_keep;
   assign push_out.cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         opcode_ff <= 8'd0;
         len_ff    <= 8'd0;
         sum_ff    <= 8'd0;
         prev_ff   <= 8'd0;
      end else begin
         pos_ff    <= pos_in;
         opcode_ff <= opcode_in;
         len_ff    <= len_in;
         sum_ff    <= sum_in;
         prev_ff   <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fd_we) begin
         first_data_ff[fd_idx] <= in_byte;
      end
   end

endmodule

>>> rtl/sfh_queue.sv
// ----------------------------------------------------------------------------
// sfh_queue
// Short command queue between the frame parser and the reply sequencer.
// ----------------------------------------------------------------------------
module sfh_queue (
   input  logic               clock,
   input  logic               reset,
   input  sfh_pkg::push_type  push_in,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output sfh_pkg::cmd_type   head
);

   localparam int unsigned DEPTH = sfh_pkg::QUEUE_DEPTH;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   sfh_pkg::cmd_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push_in.push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_in.cmd;
      end
   end

endmodule

>>> rtl/sfh_back.sv
// ----------------------------------------------------------------------------
// sfh_back
// Reply sequencer: expands one command into its reply bytes, one transfer
// per cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module sfh_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  sfh_pkg::cmd_type  head,
   output logic              pop,
   input  logic              out_ready,
   output logic              out_valid,
   output sfh_pkg::rsp_type  out_data
);

   sfh_pkg::cmd_type cur_ff, cur_in;
   logic             active_ff, active_in;
   logic [2:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   sfh_pkg::rsp_type out_ff, out_in;

   logic       out_free;
   logic       load;
   logic [2:0] last_idx;
   logic       is_last;
   logic [7:0] byte_val;
   logic [7:0] read_val;

   assign out_free = !out_valid_ff || out_ready;
   assign load     = active_ff && out_free;
   assign last_idx = (cur_ff.kind == sfh_pkg::KIND_READ) ? 3'd5 : 3'd4;
   assign is_last  = idx_ff == last_idx;
   assign pop      = head_valid && (!active_ff || (load && is_last));
   assign read_val = {7'd0, cur_ff.read_bit};

   always_comb begin
      case (idx_ff)
         3'd0: byte_val = sfh_pkg::START_BYTE;
         3'd1: begin
            if (cur_ff.kind == sfh_pkg::KIND_ERR) begin
               byte_val = sfh_pkg::ACK_ERR;
            end else if (cur_ff.kind == sfh_pkg::KIND_DAC) begin
               byte_val = sfh_pkg::ACK_DAC;
            end else begin
               byte_val = sfh_pkg::ACK_PIN;
            end
         end
         3'd2: byte_val = (cur_ff.kind == sfh_pkg::KIND_READ) ? sfh_pkg::READ_TAG
                                                               : sfh_pkg::ZERO_BYTE;
         3'd3: byte_val = (cur_ff.kind == sfh_pkg::KIND_READ) ? read_val
                                                               : sfh_pkg::ZERO_BYTE;
         3'd4: byte_val = (cur_ff.kind == sfh_pkg::KIND_READ) ? read_val
                                                               : sfh_pkg::END_BYTE;
         3'd5: byte_val = sfh_pkg::END_BYTE;
         default: byte_val = sfh_pkg::ZERO_BYTE;
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_in       = '0;
         out_in.reply_byte = byte_val;
         out_in.reply_last = is_last;
         // command side fields ride on the first reply byte only
         if (idx_ff == 3'd0) begin
            out_in.dac_write  = cur_ff.kind == sfh_pkg::KIND_DAC;
            out_in.dac_word   = cur_ff.dac_word;
            out_in.pin_action = cur_ff.pin_action;
            out_in.pin_number = cur_ff.pin_number;
            out_in.pin_drive  = cur_ff.pin_drive;
         end
         idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
         if (is_last) begin
            active_in = 1'b0;
         end
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         cur_in    = head;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

>>> rtl/serial_command_frame_handler_unit.sv
// ----------------------------------------------------------------------------
// serial_command_frame_handler_unit
// Command frame parser and reply generator for a received serial byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on the req_ side while req_tready is
// high and recognizes frames 0x69, opcode, length, data, sum of data, 0x96.
// Each valid frame becomes a command in a four-entry queue; the reply side
// turns it into a reply frame of five bytes (six for a pin read), sent from
// a registered output stage at one byte per cycle while rsp_tready is high,
// with the DAC word or pin command fields on the first reply byte. req_tready
// is low only while that command queue is full, so input keeps flowing at
// one byte per cycle whenever the reply side keeps up. Frames whose total
// length would exceed MAX_FRAME_LEN are dropped at their length byte.
module serial_command_frame_handler_unit #(
   parameter int unsigned MAX_FRAME_LEN = sfh_pkg::MAX_FRAME_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rx_byte[7:0], pin_levels[39:8]
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [39:0] rsp_tdata,   // reply_byte[7:0], dac_word[23:8],
                                    // pin_number[31:24], pin_drive[32], zero fill
   output logic        rsp_tlast,
   output logic [2:0]  rsp_tuser    // dac_write[0], pin_action[2:1]
);

   sfh_pkg::push_type push;
   sfh_pkg::cmd_type  head;
   sfh_pkg::rsp_type  rsp;
   logic              queue_full;
   logic              head_valid;
   logic              pop;

   sfh_front #(
      .MAX_FRAME_LEN (MAX_FRAME_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata[7:0]),
      .in_levels  (req_tdata[39:8]),
      .queue_full (queue_full),
      .in_ready   (req_tready),
      .push_out   (push)
   );

   sfh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   sfh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (rsp)
   );

   assign rsp_tdata = {7'd0, rsp.pin_drive, rsp.pin_number, rsp.dac_word, rsp.reply_byte};
   assign rsp_tlast = rsp.reply_last;
   assign rsp_tuser = {rsp.pin_action, rsp.dac_write};

endmodule

>>> rtl/sfh_checker.sv
// ----------------------------------------------------------------------------
// sfh_checker
// Port-level checks of the serial command frame handler.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfh_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tready,
   input logic        rsp_tvalid,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);

   logic        rsp_stall;
   logic [43:0] rsp_beat;
   logic [7:0]  rsp_byte;
   logic        rsp_cmd;
   logic        rsp_dac;
   logic        rsp_end;
   logic [1:0]  dac_mode;
   logic [1:0]  pin_act;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = {rsp_tuser, rsp_tlast, rsp_tdata};
   assign rsp_byte  = rsp_tdata[7:0];
   assign rsp_cmd   = rsp_tvalid && (rsp_tuser != 3'd0);
   assign rsp_dac   = rsp_tvalid && rsp_tuser[0];
   assign rsp_end   = rsp_tvalid && rsp_tlast;
   assign dac_mode  = rsp_tdata[21:20];
   assign pin_act   = rsp_tuser[2:1];

   // stalled reply transfer holds
   `SFH_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_beat), "stalled reply moved")

   // command fields only ride on a start byte
   `SFH_ASSERT_IMPL(a_cmd_first, rsp_cmd, rsp_byte == sfh_pkg::START_BYTE, "fields off first byte")

   // a DAC word always carries the fixed mode bits
   `SFH_ASSERT_IMPL(a_dac_mode, rsp_dac, dac_mode == sfh_pkg::DAC_MODE, "dac mode bits wrong")

   // reply frames close on the end byte
   `SFH_ASSERT_IMPL(a_last_end, rsp_end, rsp_byte == sfh_pkg::END_BYTE, "last byte not end byte")

   `SFH_ASSERT(a_no_action3, !rsp_tvalid || (pin_act <= sfh_pkg::PIN_ACT_INPUT), "bad pin action")

endmodule

bind serial_command_frame_handler_unit sfh_checker u_sfh_checker (.*);
